// ----- sv/adaptive_delta_predictive_coder_macros.svh -----
// Assertion macros for the adaptive delta predictive coder.
// Used by the top level; needs nothing else.
`ifndef ADAPTIVE_DELTA_PREDICTIVE_CODER_MACROS_SVH
`define ADAPTIVE_DELTA_PREDICTIVE_CODER_MACROS_SVH

// same-cycle implication
`define ADPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ADPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/adpc_pkg.sv -----
// Shared constants and types for the adaptive delta predictive coder.
// No dependencies.
`timescale 1ns / 1ps

package adpc_pkg;

	localparam int VALUE_W    = 32;
	localparam int ACC_W      = 31;
	localparam int LSHIFT_W   = 6;
	localparam int FRAC_W     = 5;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_SHIFT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_FRAC  = CFG_IDX_W'(1);

	localparam logic signed [LSHIFT_W-1:0] GAIN_SHIFT_RST = LSHIFT_W'(1);
	localparam logic [FRAC_W-1:0]          GAIN_FRAC_RST  = FRAC_W'(4);

	localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

	typedef enum logic {
		FUNC_ENCODE = 1'b0,
		FUNC_DECODE = 1'b1
	} func_t;

endpackage

// ----- sv/adpc_sample_if.sv -----
// Input channel: one sample or residual per item.
// Depends on adpc_pkg.
`timescale 1ns / 1ps

interface adpc_sample_if;
	logic                         valid;
	logic                         ready;
	logic                         func;
	logic [adpc_pkg::VALUE_W-1:0] value_in;

	modport source (output valid, output func, output value_in, input ready);
	modport sink   (input valid, input func, input value_in, output ready);
endinterface

// ----- sv/adpc_result_if.sv -----
// Output channel: one residual or reconstructed sample per item.
// Depends on adpc_pkg.
`timescale 1ns / 1ps

interface adpc_result_if;
	logic                         valid;
	logic                         ready;
	logic [adpc_pkg::VALUE_W-1:0] value_out;

	modport source (output valid, output value_out, input ready);
	modport sink   (input valid, input value_out, output ready);
endinterface

// ----- sv/adpc_cfg_if.sv -----
// Register write channel: index and data.
// Depends on adpc_pkg.
`timescale 1ns / 1ps

interface adpc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [adpc_pkg::CFG_IDX_W-1:0]  index;
	logic [adpc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/adaptive_delta_predictive_coder.sv -----
// Adaptive delta predictor: encodes samples to residuals (func 0) or decodes
// residuals back to samples (func 1), one item per clock sustained while the
// result side does not stall; the result passes through the input register,
// then the result register.
// The rate is set by the state feedback loop: gain shift, one 32x32 multiply,
// fraction shift, prediction add and accumulator update all close as one
// combinational path between the input register and the state/result registers.
// Config writes are always accepted; register 0 is the gain shift, 1 is
// gain_frac_bits, other indices are ignored. Depends on adpc_pkg, the three
// channel interfaces and the macros header.
`timescale 1ns / 1ps
`include "adaptive_delta_predictive_coder_macros.svh"

module adaptive_delta_predictive_coder #(
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	adpc_cfg_if.sink       cfg,
	adpc_sample_if.sink    samples,
	adpc_result_if.source  results
);

	localparam int SW = SAMPLE_WIDTH;
	localparam int VW = adpc_pkg::VALUE_W;
	localparam int AW = adpc_pkg::ACC_W;

	logic signed [adpc_pkg::LSHIFT_W-1:0] ls_q;
	logic [adpc_pkg::FRAC_W-1:0]          frac_q;

	logic                 valid_s1;
	logic                 func_s1;
	logic signed [SW-1:0] value_s1;

	logic signed [SW-1:0] prev_q;
	logic signed [SW-1:0] delta_q;
	logic [AW-1:0]        acc_q;

	logic          out_valid_q;
	logic [VW-1:0] out_value_q;

	logic advance;
	logic take;

	logic [VW-1:0]                 acc_w;
	logic [adpc_pkg::LSHIFT_W-1:0] neg_ls;
	logic [VW-1:0]                 gain;
	logic signed [VW-1:0]          delta_w;
	logic [VW-1:0]                 mag;
	logic [VW-1:0]                 prod;
	logic signed [VW-1:0]          scaled;
	logic signed [SW-1:0]          pred;
	logic signed [SW-1:0]          res;
	logic signed [SW-1:0]          smp;
	logic signed [SW-1:0]          err;
	logic signed [AW+1:0]          step;
	logic signed [AW+1:0]          acc_sum;
	logic [AW-1:0]                 acc_next;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ls_q   <= adpc_pkg::GAIN_SHIFT_RST;
			frac_q <= adpc_pkg::GAIN_FRAC_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				adpc_pkg::REG_GAIN_SHIFT: ls_q   <= cfg.data[adpc_pkg::LSHIFT_W-1:0];
				adpc_pkg::REG_GAIN_FRAC:  frac_q <= cfg.data[adpc_pkg::FRAC_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake: input register and result register, stall from the far side
	assign advance       = !out_valid_q || results.ready;
	assign take          = valid_s1 && advance;
	assign samples.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			func_s1  <= samples.func;
			value_s1 <= samples.value_in[SW-1:0];
		end
	end

	// gain: accumulator shifted right, or left (wrapping) for negative shift
	assign acc_w  = VW'(acc_q);
	assign neg_ls = -ls_q;

	always_comb begin
		if (!ls_q[adpc_pkg::LSHIFT_W-1])
			gain = acc_w >> ls_q[adpc_pkg::LSHIFT_W-2:0];
		else if (neg_ls[adpc_pkg::LSHIFT_W-1])
			gain = '0;	// shift of a whole word
		else
			gain = acc_w << neg_ls[adpc_pkg::LSHIFT_W-2:0];
	end

	// product on |delta|, sign re-applied at the add
	assign delta_w = VW'(delta_q);
	assign mag     = delta_q[SW-1] ? -delta_w : delta_w;
	assign prod    = gain * mag;
	assign scaled  = $signed(prod) >>> frac_q;
	assign pred    = delta_q[SW-1] ? prev_q - scaled[SW-1:0] : prev_q + scaled[SW-1:0];

	// residual and reconstruction both come out as pred - value
	assign res = pred - value_s1;
	assign smp = (func_s1 == adpc_pkg::FUNC_DECODE) ? res : value_s1;
	assign err = smp - pred;

	assign step    = err[SW-1] ? -(AW+2)'(delta_q) : (AW+2)'(delta_q);
	assign acc_sum = $signed({2'b00, acc_q}) + step;

	always_comb begin
		if (acc_sum[AW+1])
			acc_next = '0;
		else if (acc_sum[AW])
			acc_next = adpc_pkg::ACC_MAX;
		else
			acc_next = acc_sum[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			delta_q <= '0;
			acc_q   <= '0;
		end else if (take) begin
			prev_q  <= smp;
			delta_q <= smp - prev_q;
			acc_q   <= acc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_value_q <= VW'(res);
		end
	end

	assign results.valid     = out_valid_q;
	assign results.value_out = out_value_q;

	`ADPC_ASSERT_NEXT(a_result_loaded, clk, arst_n, take, out_valid_q, "item lost on way to result register")
	`ADPC_ASSERT_NOW(a_stall_blocks_input, clk, arst_n, out_valid_q && !results.ready && valid_s1, !samples.ready, "input accepted into a full pipe")
	`ADPC_ASSERT_NEXT(a_state_holds, clk, arst_n, !take, $stable(prev_q) && $stable(delta_q) && $stable(acc_q), "predictor state moved without an item")

endmodule
